[sv/lfdc_pkg.sv]
package lfdc_pkg;

  typedef enum logic [1:0] {
    OP_L32_TO_D = 2'd0,
    OP_L64_TO_D = 2'd1,
    OP_D_TO_L32 = 2'd2,
    OP_D_TO_L64 = 2'd3
  } op_t;

  // Exponent rebias: legacy bias 256, double bias 1023, off by one for the hidden bit.
  localparam logic [10:0] L2D_REBIAS = 11'd766;
  // 766 mod 2^9, applied on the 9-bit legacy exponent field.
  localparam logic [8:0]  D2L_REBIAS = 9'd254;
  // Half of the dropped fraction LSB for the double to legacy32 round.
  localparam logic [30:0] D2L32_HALF = 31'h4000_0000;

  typedef struct packed {
    logic vld;
    op_t  op;
    logic neg;
    logic zero;
  } ctl_t;

endpackage

[sv/legacy_float_ieee_double_convert_core.sv]
// A word accepted at start passes the input register, then the front and back datapath
// registers, and is then on out_value_out, marked by out_valid for one cycle;
// three register stages set this.
// Throughput: one word per cycle; busy stays low, every stage advances each cycle.
// The receiver cannot stall, so results are never held back.
// Reset: synchronous, active low; clears the valid bits of all stages, drops words in flight.
module legacy_float_ieee_double_convert_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [63:0] in_value_in,
  output logic        out_valid,
  output logic [63:0] out_value_out
);
  import lfdc_pkg::*;

  // Input register: capture the command word as it arrives.
  logic        vld_r;
  op_t         op_r;
  logic [63:0] val_r;
  logic        accept;
  ctl_t        in_ctl;

  // Nothing in the datapath ever holds a word back, so never push back on the sender.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= accept;
    end
    op_r  <= op_t'(in_operation);
    val_r <= in_value_in;
  end

  // Sign and zero flags are filled in by the front stage of the datapath.
  always_comb begin
    in_ctl      = '0;
    in_ctl.vld  = vld_r;
    in_ctl.op   = op_r;
  end

  // Two datapath stages: magnitude or legacy pack first, then rebias or sign apply.
  lfdc_pipe u_pipe (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ctl  (in_ctl),
    .in_val  (val_r),
    .out_vld (out_valid),
    .out_val (out_value_out)
  );

`ifndef ASSERT_OFF
  // Every accepted word gives a strobe once it has passed the three register stages.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##3 out_valid)
    else $error("accepted word did not produce a result on time");

  // No strobe without an accepted word that has passed the three register stages.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 3))
    else $error("result strobe without an accepted word");

  // An all-zero word converts to zero under every operation.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_value_in == 64'd0)) |-> ##3 (out_value_out == 64'd0))
    else $error("zero word did not convert to zero");
`endif

endmodule

[sv/lfdc_pipe.sv]
module lfdc_pipe (
  input  logic            clk,
  input  logic            rst_n,
  input  lfdc_pkg::ctl_t  in_ctl,
  input  logic [63:0]     in_val,
  output logic            out_vld,
  output logic [63:0]     out_val
);
  import lfdc_pkg::*;

  ctl_t        ctl_nxt, ctl_r;
  logic [63:0] mid_nxt, mid_r;
  logic [63:0] res_nxt, res_r;
  logic        vld_r;

  logic [31:0] neg32;
  logic [63:0] neg64;
  logic [8:0]  e9;
  logic [21:0] m22;
  logic        rnd;
  logic [22:0] m23;

  logic [10:0] e11_32, e11_64;
  logic [52:0] sum53;
  logic [31:0] r32;

  // Front: take the magnitude of legacy words, or build the unsigned legacy word.
  always_comb begin
    neg32 = 32'd0 - in_val[31:0];
    neg64 = 64'd0 - in_val;
    e9    = in_val[60:52] - D2L_REBIAS;
    m22   = {1'b1, in_val[51:31]};
    rnd   = (in_val[30:0] > D2L32_HALF);
    m23   = {1'b0, m22} + {22'd0, rnd};
    ctl_nxt      = in_ctl;
    ctl_nxt.neg  = in_val[63];
    ctl_nxt.zero = (in_val == 64'd0);
    case (in_ctl.op)
      OP_L32_TO_D: begin
        ctl_nxt.neg  = in_val[31];
        ctl_nxt.zero = (in_val[31:0] == 32'd0);
        mid_nxt = {32'd0, (in_val[31] ? neg32 : in_val[31:0])};
      end
      OP_L64_TO_D: begin
        mid_nxt = in_val[63] ? neg64 : in_val;
      end
      OP_D_TO_L32: begin
        // carry out of the rounded fraction lands on exponent bit 0 by OR
        mid_nxt = {32'd0, ({1'b0, e9, 22'd0} | {9'd0, m23})};
      end
      default: begin
        mid_nxt = {1'b0, e9, 1'b1, in_val[51:0], 1'b0};
      end
    endcase
  end

  // Back: rebias legacy fields into a double, or apply the sign to a legacy word.
  always_comb begin
    e11_32 = {2'd0, mid_r[30:22]} + L2D_REBIAS;
    e11_64 = {2'd0, mid_r[62:54]} + L2D_REBIAS;
    sum53  = {1'b0, mid_r[52:1]} + {52'd0, mid_r[0]};
    r32    = ctl_r.neg ? (32'd0 - mid_r[31:0]) : mid_r[31:0];
    case (ctl_r.op)
      OP_L32_TO_D: res_nxt = {ctl_r.neg, e11_32, mid_r[20:0], 31'd0};
      OP_L64_TO_D: res_nxt = {ctl_r.neg, e11_64, 52'd0} | {11'd0, sum53};
      OP_D_TO_L32: res_nxt = {32'd0, r32};
      default:     res_nxt = ctl_r.neg ? (64'd0 - mid_r) : mid_r;
    endcase
    if (ctl_r.zero) begin
      res_nxt = 64'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.vld <= 1'b0;
      vld_r     <= 1'b0;
    end else begin
      ctl_r.vld <= ctl_nxt.vld;
      vld_r     <= ctl_r.vld;
    end
    ctl_r.op   <= ctl_nxt.op;
    ctl_r.neg  <= ctl_nxt.neg;
    ctl_r.zero <= ctl_nxt.zero;
    mid_r      <= mid_nxt;
    res_r      <= res_nxt;
  end

  assign out_vld = vld_r;
  assign out_val = res_r;

endmodule
